@@ design/qs_pkg.sv @@
// quaternion slerp shared constants, arctangent table and fixed widths
`default_nettype none
package qs_pkg;

  // fixed formats of the angle, sine and weight datapath
  localparam int ANG_FRAC  = 30;
  localparam int SQ_W      = 64;
  localparam int VEC_XW    = 34;
  localparam int ANG_W     = 33;
  localparam int ROT_W     = 33;
  localparam int DEN_W     = 32;
  localparam int REM_W     = 33;
  localparam int WQ_W      = 31;
  localparam int T_W       = 17;
  localparam int THR_W     = 29;
  localparam int MAX_ITERS = 32;

  localparam logic [T_W-1:0]   T_ONE      = 17'd65536;
  localparam logic [WQ_W-1:0]  ONE_Q30    = 31'h4000_0000;
  localparam logic [THR_W-1:0] THR_RESET  = 29'd26844;
  localparam logic [SQ_W-1:0]  SQ_ONE     = 64'd1;
  localparam logic [SQ_W-1:0]  SQ_ARG_TOP = 64'h1000_0000_0000_0000;

  // atan(2^-i) scaled by 2^30, truncated
  localparam logic [31:0] ATAN_TAB [0:MAX_ITERS-1] = '{
    32'h3243F6A8, 32'h1DAC6705, 32'h0FADBAFC, 32'h07F56EA6, 32'h03FEAB76, 32'h01FFD55B,
    32'h00FFFAAA, 32'h007FFF55, 32'h003FFFEA, 32'h001FFFFD, 32'h000FFFFF, 32'h0007FFFF,
    32'h0003FFFF, 32'h0001FFFF, 32'h0000FFFF, 32'h00007FFF, 32'h00003FFF, 32'h00001FFF,
    32'h00000FFF, 32'h000007FF, 32'h000003FF, 32'h000001FF, 32'h000000FF, 32'h0000007F,
    32'h0000003F, 32'h0000001F, 32'h0000000F, 32'h00000007, 32'h00000003, 32'h00000001,
    32'h00000000, 32'h00000000
  };

endpackage
`default_nettype wire

@@ design/qs_in_if.sv @@
// input channel: two quaternions and a blend factor
`default_nettype none
interface qs_in_if #(parameter int COMPONENT_WIDTH = 16);
  logic                              valid;
  logic                              ready;
  logic signed [COMPONENT_WIDTH-1:0] start_x;
  logic signed [COMPONENT_WIDTH-1:0] start_y;
  logic signed [COMPONENT_WIDTH-1:0] start_z;
  logic signed [COMPONENT_WIDTH-1:0] start_w;
  logic signed [COMPONENT_WIDTH-1:0] end_x;
  logic signed [COMPONENT_WIDTH-1:0] end_y;
  logic signed [COMPONENT_WIDTH-1:0] end_z;
  logic signed [COMPONENT_WIDTH-1:0] end_w;
  logic [16:0]                       blend_factor;

  modport source (output valid, start_x, start_y, start_z, start_w, end_x, end_y, end_z,
                  end_w, blend_factor, input ready);
  modport sink (input valid, start_x, start_y, start_z, start_w, end_x, end_y, end_z,
                end_w, blend_factor, output ready);
endinterface
`default_nettype wire

@@ design/qs_out_if.sv @@
// output channel: interpolated quaternion and flags
`default_nettype none
interface qs_out_if #(parameter int COMPONENT_WIDTH = 16);
  logic                              valid;
  logic                              ready;
  logic signed [COMPONENT_WIDTH-1:0] out_x;
  logic signed [COMPONENT_WIDTH-1:0] out_y;
  logic signed [COMPONENT_WIDTH-1:0] out_z;
  logic signed [COMPONENT_WIDTH-1:0] out_w;
  logic                              linear_used;
  logic                              end_negated;

  modport source (output valid, out_x, out_y, out_z, out_w, linear_used, end_negated,
                  input ready);
  modport sink (input valid, out_x, out_y, out_z, out_w, linear_used, end_negated,
                output ready);
endinterface
`default_nettype wire

@@ design/qs_sqrt_cell.sv @@
// one step of the bitwise integer square root
`default_nettype none
module qs_sqrt_cell #(
  parameter int IDX    = 0,
  parameter int SIDE_W = 1
) (
  input  wire                   clk,
  input  wire                   rst,
  input  wire                   en,
  input  wire                   in_valid,
  input  wire [qs_pkg::SQ_W-1:0] in_v,
  input  wire [qs_pkg::SQ_W-1:0] in_res,
  input  wire [SIDE_W-1:0]      in_side,
  output logic                  out_valid,
  output logic [qs_pkg::SQ_W-1:0] out_v,
  output logic [qs_pkg::SQ_W-1:0] out_res,
  output logic [SIDE_W-1:0]     out_side
);
  import qs_pkg::*;

  localparam logic [SQ_W-1:0] BIT_VAL = SQ_ONE << (62 - 2 * IDX);

  logic [SQ_W-1:0] trial;
  logic [SQ_W-1:0] v_next;
  logic [SQ_W-1:0] res_next;

  // trial subtract of the current root bit
  always_comb begin
    trial = in_res + BIT_VAL;
    if (in_v >= trial) begin
      v_next   = in_v - trial;
      res_next = (in_res >> 1) + BIT_VAL;
    end else begin
      v_next   = in_v;
      res_next = in_res >> 1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (en) begin
      out_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      out_v    <= v_next;
      out_res  <= res_next;
      out_side <= in_side;
    end
  end
endmodule
`default_nettype wire

@@ design/qs_vec_cell.sv @@
// one vectoring cordic iteration, accumulates the angle
`default_nettype none
module qs_vec_cell #(
  parameter int IDX    = 0,
  parameter int SIDE_W = 1
) (
  input  wire                             clk,
  input  wire                             rst,
  input  wire                             en,
  input  wire                             in_valid,
  input  wire signed [qs_pkg::VEC_XW-1:0] in_x,
  input  wire signed [qs_pkg::VEC_XW-1:0] in_y,
  input  wire signed [qs_pkg::ANG_W-1:0]  in_z,
  input  wire [SIDE_W-1:0]                in_side,
  output logic                            out_valid,
  output logic signed [qs_pkg::VEC_XW-1:0] out_x,
  output logic signed [qs_pkg::VEC_XW-1:0] out_y,
  output logic signed [qs_pkg::ANG_W-1:0]  out_z,
  output logic [SIDE_W-1:0]               out_side
);
  import qs_pkg::*;

  localparam logic signed [ANG_W-1:0] ATAN_I = $signed({1'b0, ATAN_TAB[IDX]});

  logic signed [VEC_XW-1:0] x_next;
  logic signed [VEC_XW-1:0] y_next;
  logic signed [ANG_W-1:0]  z_next;

  // drive y toward zero
  always_comb begin
    if (in_y >= 0) begin
      x_next = in_x + (in_y >>> IDX);
      y_next = in_y - (in_x >>> IDX);
      z_next = in_z + ATAN_I;
    end else begin
      x_next = in_x - (in_y >>> IDX);
      y_next = in_y + (in_x >>> IDX);
      z_next = in_z - ATAN_I;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (en) begin
      out_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      out_x    <= x_next;
      out_y    <= y_next;
      out_z    <= z_next;
      out_side <= in_side;
    end
  end
endmodule
`default_nettype wire

@@ design/qs_rot_cell.sv @@
// one rotation cordic iteration over several angle lanes
`default_nettype none
module qs_rot_cell #(
  parameter int IDX    = 0,
  parameter int SIDE_W = 1,
  parameter int LANES  = 3
) (
  input  wire                            clk,
  input  wire                            rst,
  input  wire                            en,
  input  wire                            in_valid,
  input  wire signed [qs_pkg::ROT_W-1:0] in_x [LANES],
  input  wire signed [qs_pkg::ROT_W-1:0] in_y [LANES],
  input  wire signed [qs_pkg::ROT_W-1:0] in_a [LANES],
  input  wire [SIDE_W-1:0]               in_side,
  output logic                           out_valid,
  output logic signed [qs_pkg::ROT_W-1:0] out_x [LANES],
  output logic signed [qs_pkg::ROT_W-1:0] out_y [LANES],
  output logic signed [qs_pkg::ROT_W-1:0] out_a [LANES],
  output logic [SIDE_W-1:0]              out_side
);
  import qs_pkg::*;

  localparam logic signed [ROT_W-1:0] ATAN_I = $signed({1'b0, ATAN_TAB[IDX]});

  logic signed [ROT_W-1:0] x_next [LANES];
  logic signed [ROT_W-1:0] y_next [LANES];
  logic signed [ROT_W-1:0] a_next [LANES];

  // drive each residual angle toward zero
  always_comb begin
    for (int k = 0; k < LANES; k++) begin
      if (in_a[k] >= 0) begin
        x_next[k] = in_x[k] - (in_y[k] >>> IDX);
        y_next[k] = in_y[k] + (in_x[k] >>> IDX);
        a_next[k] = in_a[k] - ATAN_I;
      end else begin
        x_next[k] = in_x[k] + (in_y[k] >>> IDX);
        y_next[k] = in_y[k] - (in_x[k] >>> IDX);
        a_next[k] = in_a[k] + ATAN_I;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (en) begin
      out_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      out_x    <= x_next;
      out_y    <= y_next;
      out_a    <= a_next;
      out_side <= in_side;
    end
  end
endmodule
`default_nettype wire

@@ design/qs_div_cell.sv @@
// one restoring division step over several lanes, one quotient bit each
`default_nettype none
module qs_div_cell #(
  parameter int IDX    = 0,
  parameter int SIDE_W = 1,
  parameter int LANES  = 2
) (
  input  wire                     clk,
  input  wire                     rst,
  input  wire                     en,
  input  wire                     in_valid,
  input  wire [qs_pkg::DEN_W-1:0] in_den [LANES],
  input  wire [qs_pkg::REM_W-1:0] in_rem [LANES],
  input  wire [qs_pkg::WQ_W-1:0]  in_q [LANES],
  input  wire [SIDE_W-1:0]        in_side,
  output logic                    out_valid,
  output logic [qs_pkg::DEN_W-1:0] out_den [LANES],
  output logic [qs_pkg::REM_W-1:0] out_rem [LANES],
  output logic [qs_pkg::WQ_W-1:0]  out_q [LANES],
  output logic [SIDE_W-1:0]       out_side
);
  import qs_pkg::*;

  logic [REM_W:0]  rem2 [LANES];
  logic [REM_W-1:0] rem_next [LANES];
  logic [WQ_W-1:0] q_next [LANES];

  // first step tests the dividend as is, later steps shift in a zero
  always_comb begin
    for (int k = 0; k < LANES; k++) begin
      if (IDX == 0) begin
        rem2[k] = {1'b0, in_rem[k]};
      end else begin
        rem2[k] = {in_rem[k], 1'b0};
      end
      if (rem2[k] >= (REM_W + 1)'(in_den[k])) begin
        rem_next[k] = REM_W'(rem2[k] - (REM_W + 1)'(in_den[k]));
        q_next[k]   = {in_q[k][WQ_W-2:0], 1'b1};
      end else begin
        rem_next[k] = REM_W'(rem2[k]);
        q_next[k]   = {in_q[k][WQ_W-2:0], 1'b0};
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (en) begin
      out_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      out_den  <= in_den;
      out_rem  <= rem_next;
      out_q    <= q_next;
      out_side <= in_side;
    end
  end
endmodule
`default_nettype wire

@@ design/quaternion_slerp_top.sv @@
// Quaternion slerp block: spherical interpolation between two quaternions.
// Channel in_ch takes start and end quaternions (signed Q2.F) and a blend
// factor (unsigned Q1.16); channel out_ch gives the interpolated quaternion,
// saturated, with flags for the linear fallback and the end negation.
// cfg_we/cfg_data write the linear threshold on one minus cosine; write it
// only while no item is in flight.
// Throughput: one item per cycle while out_ch is not stalled. The pipeline
// is a chain of cells: 32 square-root steps, N = min(CORDIC_ITERATIONS, 32)
// vectoring cordic steps (acos), N rotation steps (three sines side by side),
// 31 division steps for the two weights, plus product, dot product, square,
// square-root operand, angle, division setup, weight, multiply and rounding
// stages.
// Reset clears every valid bit and loads the threshold reset value.
// When out_ch.ready is low with a result waiting, the whole pipeline holds
// and in_ch.ready drops in the same cycle; otherwise in_ch.ready is high.
`default_nettype none
module quaternion_slerp_top #(
  parameter int COMPONENT_WIDTH   = 16,
  parameter int CORDIC_ITERATIONS = 16
) (
  input  wire                       clk,
  input  wire                       rst,
  qs_in_if.sink                     in_ch,
  qs_out_if.source                  out_ch,
  input  wire                       cfg_we,
  input  wire [qs_pkg::THR_W-1:0]   cfg_data
);
  import qs_pkg::*;

  localparam int W     = COMPONENT_WIDTH;
  localparam int F     = W - 2;
  localparam int DF    = 2 * F;
  localparam int NI    = (CORDIC_ITERATIONS < MAX_ITERS) ? CORDIC_ITERATIONS : MAX_ITERS;
  localparam int NS    = 32;
  localparam int ND    = WQ_W;
  localparam int HSX   = (2 * W > 61) ? 2 * W : 61;
  localparam int CMPW  = (DF + 1 > THR_W) ? DF + 1 : THR_W;
  localparam int SH_R  = (DF >= ANG_FRAC) ? DF - ANG_FRAC : 0;
  localparam int SH_L  = (DF < ANG_FRAC) ? ANG_FRAC - DF : 0;
  localparam int CXW   = DF + 1 + SH_L;
  localparam int ACC_W = W + 34;
  localparam int R_W   = W + 4;

  localparam logic signed [HSX-1:0]   HS_LIM  = HSX'(64'd1) << 59;
  localparam logic [HSX+1:0]          DOT_ONE = (HSX + 2)'(64'd1) << DF;
  localparam logic signed [ACC_W-1:0] RND_HALF = ACC_W'(64'd1) << (ANG_FRAC - 1);
  localparam logic signed [R_W-1:0]   R_MAX   = R_W'((64'd1 << (W - 1)) - 64'd1);
  localparam logic signed [R_W-1:0]   R_MIN   = -R_MAX - R_W'(1);

  typedef struct packed {
    logic [3:0][W-1:0] s;
    logic [3:0][W:0]   e;
    logic [T_W-1:0]    t;
    logic [30:0]       c30;
    logic              neg;
    logic              sloped;
    logic              lin;
    logic [1:0]        pos;
    logic [1:0]        ovf;
  } side_t;

  localparam int SIDE_W = $bits(side_t);

  logic en;
  logic [THR_W-1:0] lin_thr;

  // threshold register
  always_ff @(posedge clk) begin
    if (rst) begin
      lin_thr <= THR_RESET;
    end else if (cfg_we) begin
      lin_thr <= cfg_data;
    end
  end

  // whole pipeline advances unless a result waits on a stalled receiver
  logic o_valid;
  assign en          = !o_valid || out_ch.ready;
  assign in_ch.ready = en;

  // stage 1: component products
  logic [W-1:0] in_s [4];
  logic [W-1:0] in_e [4];
  logic [T_W-1:0] t_sat;
  logic s1_valid;
  logic signed [2*W-1:0] s1_p [4];
  side_t s1_side;

  always_comb begin
    in_s[0] = in_ch.start_x;
    in_s[1] = in_ch.start_y;
    in_s[2] = in_ch.start_z;
    in_s[3] = in_ch.start_w;
    in_e[0] = in_ch.end_x;
    in_e[1] = in_ch.end_y;
    in_e[2] = in_ch.end_z;
    in_e[3] = in_ch.end_w;
    t_sat   = (in_ch.blend_factor > T_ONE) ? T_ONE : in_ch.blend_factor;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (en) begin
      s1_valid <= in_ch.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < 4; i++) begin
        s1_p[i]        <= $signed(in_s[i]) * $signed(in_e[i]);
        s1_side.s[i]   <= in_s[i];
        s1_side.e[i]   <= (W + 1)'($signed(in_e[i]));
      end
      s1_side.t      <= t_sat;
      s1_side.c30    <= '0;
      s1_side.neg    <= 1'b0;
      s1_side.sloped <= 1'b0;
      s1_side.lin    <= 1'b0;
      s1_side.pos    <= '0;
      s1_side.ovf    <= '0;
    end
  end

  // stage 2: dot product, shorter path, branch decision, cosine in Q.30
  logic signed [HSX-1:0]  hs;
  logic signed [HSX-1:0]  hs_c;
  logic [3:0]             ls;
  logic signed [HSX+1:0]  dot;
  logic [HSX+1:0]         mag;
  logic [DF:0]            cosv;
  logic [DF:0]            one_minus;
  logic                   sloped;
  logic [CXW-1:0]         c_wide;
  side_t                  s2_next;

  always_comb begin
    hs = '0;
    ls = '0;
    for (int i = 0; i < 4; i++) begin
      hs = hs + HSX'(s1_p[i] >>> 2);
      ls = ls + 4'(s1_p[i][1:0]);
    end
    if (hs > HS_LIM) begin
      hs_c = HS_LIM;
    end else if (hs < -HS_LIM) begin
      hs_c = -HS_LIM;
    end else begin
      hs_c = hs;
    end
    dot       = $signed({hs_c, 2'b00}) + $signed((HSX + 2)'(ls));
    mag       = (dot < 0) ? $unsigned(-dot) : $unsigned(dot);
    cosv      = (mag > DOT_ONE) ? DOT_ONE[DF:0] : mag[DF:0];
    one_minus = DOT_ONE[DF:0] - cosv;
    sloped    = CMPW'(one_minus) > CMPW'(lin_thr);
    c_wide    = CXW'(cosv) << SH_L;
    s2_next   = s1_side;
    s2_next.neg    = dot < 0;
    s2_next.sloped = sloped;
    s2_next.c30    = 31'(c_wide >> SH_R);
    for (int i = 0; i < 4; i++) begin
      if (dot < 0) begin
        s2_next.e[i] = -s1_side.e[i];
      end
    end
  end

  logic  s2_valid;
  side_t s2_side;

  always_ff @(posedge clk) begin
    if (rst) begin
      s2_valid <= 1'b0;
    end else if (en) begin
      s2_valid <= s1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s2_side <= s2_next;
    end
  end

  // stage 3: cosine squared
  logic        s3_valid;
  logic [61:0] s3_sq;
  side_t       s3_side;

  always_ff @(posedge clk) begin
    if (rst) begin
      s3_valid <= 1'b0;
    end else if (en) begin
      s3_valid <= s2_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s3_sq   <= s2_side.c30 * s2_side.c30;
      s3_side <= s2_side;
    end
  end

  // stage 4: one minus cosine squared, operand of the square root
  logic            s4_valid;
  logic [SQ_W-1:0] s4_v;
  side_t           s4_side;

  always_ff @(posedge clk) begin
    if (rst) begin
      s4_valid <= 1'b0;
    end else if (en) begin
      s4_valid <= s3_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s4_v    <= SQ_ARG_TOP - SQ_W'(s3_sq);
      s4_side <= s3_side;
    end
  end

  // square root chain, sine of omega
  logic            sq_valid [0:NS];
  logic [SQ_W-1:0] sq_v     [0:NS];
  logic [SQ_W-1:0] sq_res   [0:NS];
  logic [SIDE_W-1:0] sq_side [0:NS];

  assign sq_valid[0] = s4_valid;
  assign sq_v[0]     = s4_v;
  assign sq_res[0]   = '0;
  assign sq_side[0]  = s4_side;

  for (genvar g = 0; g < NS; g++) begin : g_sqrt
    qs_sqrt_cell #(.IDX(g), .SIDE_W(SIDE_W)) u_cell (
      .clk      (clk),
      .rst      (rst),
      .en       (en),
      .in_valid (sq_valid[g]),
      .in_v     (sq_v[g]),
      .in_res   (sq_res[g]),
      .in_side  (sq_side[g]),
      .out_valid(sq_valid[g+1]),
      .out_v    (sq_v[g+1]),
      .out_res  (sq_res[g+1]),
      .out_side (sq_side[g+1])
    );
  end

  // vectoring chain, omega = atan2(sine, cosine)
  side_t sq_last;
  logic                     vc_valid [0:NI];
  logic signed [VEC_XW-1:0] vc_x     [0:NI];
  logic signed [VEC_XW-1:0] vc_y     [0:NI];
  logic signed [ANG_W-1:0]  vc_z     [0:NI];
  logic [SIDE_W-1:0]        vc_side  [0:NI];

  assign sq_last     = sq_side[NS];
  assign vc_valid[0] = sq_valid[NS];
  assign vc_x[0]     = $signed({3'b000, sq_last.c30});
  assign vc_y[0]     = $signed(sq_res[NS][VEC_XW-1:0]);
  assign vc_z[0]     = '0;
  assign vc_side[0]  = sq_side[NS];

  for (genvar g = 0; g < NI; g++) begin : g_vec
    qs_vec_cell #(.IDX(g), .SIDE_W(SIDE_W)) u_cell (
      .clk      (clk),
      .rst      (rst),
      .en       (en),
      .in_valid (vc_valid[g]),
      .in_x     (vc_x[g]),
      .in_y     (vc_y[g]),
      .in_z     (vc_z[g]),
      .in_side  (vc_side[g]),
      .out_valid(vc_valid[g+1]),
      .out_x    (vc_x[g+1]),
      .out_y    (vc_y[g+1]),
      .out_z    (vc_z[g+1]),
      .out_side (vc_side[g+1])
    );
  end

  // angle stage: clamp omega, scale by 1-t and t
  side_t       vc_last;
  logic [30:0] omega;
  logic        an_valid;
  logic [30:0] an_om;
  logic [47:0] an_pp;
  logic [47:0] an_pq;
  side_t       an_side;

  assign vc_last = vc_side[NI];
  assign omega   = (vc_z[NI] < 0) ? '0 : vc_z[NI][30:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      an_valid <= 1'b0;
    end else if (en) begin
      an_valid <= vc_valid[NI];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      an_om   <= omega;
      an_pp   <= (T_ONE - vc_last.t) * omega;
      an_pq   <= vc_last.t * omega;
      an_side <= vc_last;
    end
  end

  // rotation chain, lanes: sin(omega), sin((1-t) omega), sin(t omega)
  logic                    rt_valid [0:NI];
  logic signed [ROT_W-1:0] rt_x     [0:NI][3];
  logic signed [ROT_W-1:0] rt_y     [0:NI][3];
  logic signed [ROT_W-1:0] rt_a     [0:NI][3];
  logic [SIDE_W-1:0]       rt_side  [0:NI];

  always_comb begin
    rt_valid[0] = an_valid;
    rt_side[0]  = an_side;
    for (int k = 0; k < 3; k++) begin
      rt_x[0][k] = $signed({2'b00, ONE_Q30});
      rt_y[0][k] = '0;
    end
    rt_a[0][0] = $signed({2'b00, an_om});
    rt_a[0][1] = $signed({1'b0, an_pp[47:16]});
    rt_a[0][2] = $signed({1'b0, an_pq[47:16]});
  end

  for (genvar g = 0; g < NI; g++) begin : g_rot
    qs_rot_cell #(.IDX(g), .SIDE_W(SIDE_W), .LANES(3)) u_cell (
      .clk      (clk),
      .rst      (rst),
      .en       (en),
      .in_valid (rt_valid[g]),
      .in_x     (rt_x[g]),
      .in_y     (rt_y[g]),
      .in_a     (rt_a[g]),
      .in_side  (rt_side[g]),
      .out_valid(rt_valid[g+1]),
      .out_x    (rt_x[g+1]),
      .out_y    (rt_y[g+1]),
      .out_a    (rt_a[g+1]),
      .out_side (rt_side[g+1])
    );
  end

  // division setup: branch choice, numerator sign and range
  side_t              rt_last;
  side_t              pr_next;
  logic [DEN_W-1:0]   den;
  logic               pr_valid;
  logic [DEN_W-1:0]   pr_den [2];
  logic [REM_W-1:0]   pr_rem [2];
  side_t              pr_side;

  always_comb begin
    rt_last     = rt_side[NI];
    den         = rt_y[NI][0][DEN_W-1:0];
    pr_next     = rt_last;
    pr_next.lin = !(rt_last.sloped && (rt_y[NI][0] > 0));
    for (int k = 0; k < 2; k++) begin
      pr_next.pos[k] = rt_y[NI][k+1] > 0;
      pr_next.ovf[k] = 35'(rt_y[NI][k+1]) >= $signed({2'b00, den, 1'b0});
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pr_valid <= 1'b0;
    end else if (en) begin
      pr_valid <= rt_valid[NI];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int k = 0; k < 2; k++) begin
        pr_den[k] <= den;
        pr_rem[k] <= REM_W'(rt_y[NI][k+1]);
      end
      pr_side <= pr_next;
    end
  end

  // division chain, weight numerators over sin(omega)
  logic              dv_valid [0:ND];
  logic [DEN_W-1:0]  dv_den   [0:ND][2];
  logic [REM_W-1:0]  dv_rem   [0:ND][2];
  logic [WQ_W-1:0]   dv_q     [0:ND][2];
  logic [SIDE_W-1:0] dv_side  [0:ND];

  always_comb begin
    dv_valid[0] = pr_valid;
    dv_side[0]  = pr_side;
    for (int k = 0; k < 2; k++) begin
      dv_den[0][k] = pr_den[k];
      dv_rem[0][k] = pr_rem[k];
      dv_q[0][k]   = '0;
    end
  end

  for (genvar g = 0; g < ND; g++) begin : g_div
    qs_div_cell #(.IDX(g), .SIDE_W(SIDE_W), .LANES(2)) u_cell (
      .clk      (clk),
      .rst      (rst),
      .en       (en),
      .in_valid (dv_valid[g]),
      .in_den   (dv_den[g]),
      .in_rem   (dv_rem[g]),
      .in_q     (dv_q[g]),
      .in_side  (dv_side[g]),
      .out_valid(dv_valid[g+1]),
      .out_den  (dv_den[g+1]),
      .out_rem  (dv_rem[g+1]),
      .out_q    (dv_q[g+1]),
      .out_side (dv_side[g+1])
    );
  end

  // weight selection: linear, sine ratio, zero or clamped to one
  side_t            dv_last;
  logic [WQ_W-1:0]  w_next [2];
  logic [WQ_W-1:0]  w_lin  [2];
  logic             wt_valid;
  logic [WQ_W-1:0]  wt_w [2];
  side_t            wt_side;

  always_comb begin
    dv_last  = dv_side[ND];
    w_lin[0] = {T_ONE - dv_last.t, 14'b0};
    w_lin[1] = {dv_last.t, 14'b0};
    for (int k = 0; k < 2; k++) begin
      if (dv_last.lin) begin
        w_next[k] = w_lin[k];
      end else if (!dv_last.pos[k]) begin
        w_next[k] = '0;
      end else if (dv_last.ovf[k] || (dv_q[ND][k] > ONE_Q30)) begin
        w_next[k] = ONE_Q30;
      end else begin
        w_next[k] = dv_q[ND][k];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wt_valid <= 1'b0;
    end else if (en) begin
      wt_valid <= dv_valid[ND];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      wt_w    <= w_next;
      wt_side <= dv_last;
    end
  end

  // weighted products
  logic                  mu_valid;
  logic signed [W+31:0]  mu_p [4];
  logic signed [W+32:0]  mu_q [4];
  logic                  mu_lin;
  logic                  mu_neg;

  always_ff @(posedge clk) begin
    if (rst) begin
      mu_valid <= 1'b0;
    end else if (en) begin
      mu_valid <= wt_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < 4; i++) begin
        mu_p[i] <= $signed({1'b0, wt_w[0]}) * $signed(wt_side.s[i]);
        mu_q[i] <= $signed({1'b0, wt_w[1]}) * $signed(wt_side.e[i]);
      end
      mu_lin <= wt_side.lin;
      mu_neg <= wt_side.neg;
    end
  end

  // sum, round half up, saturate into the output register
  logic signed [ACC_W-1:0] acc [4];
  logic signed [R_W-1:0]   rq  [4];
  logic [W-1:0]            r_sat [4];
  logic [W-1:0]            o_c [4];
  logic                    o_lin;
  logic                    o_neg;

  always_comb begin
    for (int i = 0; i < 4; i++) begin
      acc[i] = ACC_W'(mu_p[i]) + ACC_W'(mu_q[i]) + RND_HALF;
      rq[i]  = $signed(acc[i][ACC_W-1:ANG_FRAC]);
      if (rq[i] > R_MAX) begin
        r_sat[i] = R_MAX[W-1:0];
      end else if (rq[i] < R_MIN) begin
        r_sat[i] = R_MIN[W-1:0];
      end else begin
        r_sat[i] = rq[i][W-1:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      o_valid <= 1'b0;
    end else if (en) begin
      o_valid <= mu_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      o_c   <= r_sat;
      o_lin <= mu_lin;
      o_neg <= mu_neg;
    end
  end

  assign out_ch.valid       = o_valid;
  assign out_ch.out_x       = o_c[0];
  assign out_ch.out_y       = o_c[1];
  assign out_ch.out_z       = o_c[2];
  assign out_ch.out_w       = o_c[3];
  assign out_ch.linear_used = o_lin;
  assign out_ch.end_negated = o_neg;

endmodule
`default_nettype wire

@@ tb/qs_tb_if.sv @@
// testbench item types for the quaternion slerp checks
`timescale 1ns / 1ps
package qs_tb_types;
  // one slerp input item and one interpolated result
  typedef struct {
    logic signed [15:0] sx, sy, sz, sw, ex, ey, ez, ew;
    logic [16:0]        blend;
  } quat_pair_t;
  typedef struct {
    logic signed [15:0] ox, oy, oz, ow;
    logic               lin, neg;
  } slerp_out_t;
endpackage

@@ tb/quaternion_slerp_top_test.sv @@
// testbench for the quaternion slerp block: directed table, random items, predictor check
`timescale 1ns / 1ps
module quaternion_slerp_top_test;
  import qs_pkg::*;
  import qs_tb_types::*;

  localparam int ITERS = 16;
  localparam int LATENCY = 104;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic cfg_we = 1'b0;
  logic [THR_W-1:0] cfg_data = '0;

  qs_in_if  #(16) in_ch ();
  qs_out_if #(16) out_ch ();

  quaternion_slerp_top #(.COMPONENT_WIDTH(16), .CORDIC_ITERATIONS(ITERS)) uut (
    .clk(clk), .rst(rst), .in_ch(in_ch), .out_ch(out_ch),
    .cfg_we(cfg_we), .cfg_data(cfg_data)
  );

  // clock
  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // predictor state
  logic [THR_W-1:0] thr_shadow = THR_RESET;
  slerp_out_t pending_q[$];
  int mismatches = 0;
  int results_seen = 0;
  int linear_seen = 0;
  int negated_seen = 0;
  bit stim_done = 0;

  function automatic longint int_sqrt(longint unsigned v);
    longint unsigned res, bitv;
    res = 0;
    bitv = 64'd1 << 62;
    for (int i = 0; i < 32; i++) begin
      if (v >= res + bitv) begin
        v = v - (res + bitv);
        res = (res >> 1) + bitv;
      end else begin
        res = res >> 1;
      end
      bitv = bitv >> 2;
    end
    return longint'(res);
  endfunction

  // vectoring cordic: angle of (x, y)
  function automatic longint vec_angle(longint x, longint y);
    longint z, nx;
    z = 0;
    for (int i = 0; i < ITERS; i++) begin
      if (y >= 0) begin
        nx = x + (y >>> i);
        y = y - (x >>> i);
        z += longint'(ATAN_TAB[i]);
      end else begin
        nx = x - (y >>> i);
        y = y + (x >>> i);
        z -= longint'(ATAN_TAB[i]);
      end
      x = nx;
    end
    return z;
  endfunction

  // rotation cordic: gain-scaled sine
  function automatic longint gain_sine(longint a);
    longint x, y, nx;
    x = longint'(1) << 30;
    y = 0;
    for (int i = 0; i < ITERS; i++) begin
      if (a >= 0) begin
        nx = x - (y >>> i);
        y = y + (x >>> i);
        a -= longint'(ATAN_TAB[i]);
      end else begin
        nx = x + (y >>> i);
        y = y - (x >>> i);
        a += longint'(ATAN_TAB[i]);
      end
      x = nx;
    end
    return y;
  endfunction

  function automatic longint ratio_weight(longint num, longint den);
    longint unsigned q;
    if (num <= 0) return 0;
    q = (longint'(num) << 30) / longint'(den);
    return (q > (64'd1 << 30)) ? (longint'(1) << 30) : longint'(q);
  endfunction

  function automatic slerp_out_t slerp_predict(quat_pair_t it, logic [THR_W-1:0] thr);
    slerp_out_t r;
    longint s[4], e[4], p, hs, ls, dotp, mag, cosv, omega, wp, wq, t, sinom, acc, rr;
    longint one, lim;
    bit neg, lin;
    s = '{it.sx, it.sy, it.sz, it.sw};
    e = '{it.ex, it.ey, it.ez, it.ew};
    one = longint'(1) << 28;
    lim = longint'(1) << 59;
    hs = 0;
    ls = 0;
    lin = 1;
    // exact dot product
    for (int i = 0; i < 4; i++) begin
      p = s[i] * e[i];
      hs += p >>> 2;
      ls += p & 3;
    end
    if (hs > lim) hs = lim;
    if (hs < -lim) hs = -lim;
    dotp = hs * 4 + ls;
    neg = dotp < 0;
    mag = neg ? -dotp : dotp;
    cosv = mag > one ? one : mag;
    if (neg) for (int i = 0; i < 4; i++) e[i] = -e[i];
    t = it.blend;
    if (t > 65536) t = 65536;
    wp = (65536 - t) << 14;
    wq = t << 14;
    // spherical weights when far enough apart
    if ((one - cosv) > longint'(thr)) begin
      longint c30;
      c30 = cosv << 2;
      omega = vec_angle(c30, int_sqrt((64'd1 << 60) - c30 * c30));
      if (omega < 0) omega = 0;
      sinom = gain_sine(omega);
      if (sinom > 0) begin
        lin = 0;
        wp = ratio_weight(gain_sine(((65536 - t) * omega) >>> 16), sinom);
        wq = ratio_weight(gain_sine((t * omega) >>> 16), sinom);
      end
    end
    for (int i = 0; i < 4; i++) begin
      acc = wp * s[i] + wq * e[i];
      rr = (acc + (longint'(1) << 29)) >>> 30;
      if (rr > 32767) rr = 32767;
      if (rr < -32768) rr = -32768;
      case (i)
        0: r.ox = rr[15:0];
        1: r.oy = rr[15:0];
        2: r.oz = rr[15:0];
        default: r.ow = rr[15:0];
      endcase
    end
    r.lin = lin;
    r.neg = neg;
    return r;
  endfunction

  // pick a gap: mostly none or short, sometimes long
  function automatic int pick_gap();
    int k;
    k = $urandom_range(0, 99);
    if (k < 55) return 0;
    if (k < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 30);
  endfunction

  task automatic send_item(quat_pair_t it);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_ch.valid <= 1'b1;
    in_ch.start_x <= it.sx;
    in_ch.start_y <= it.sy;
    in_ch.start_z <= it.sz;
    in_ch.start_w <= it.sw;
    in_ch.end_x <= it.ex;
    in_ch.end_y <= it.ey;
    in_ch.end_z <= it.ez;
    in_ch.end_w <= it.ew;
    in_ch.blend_factor <= it.blend;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    pending_q.push_back(slerp_predict(it, thr_shadow));
  endtask

  task automatic drain_and_write(logic [THR_W-1:0] v);
    in_ch.valid <= 1'b0;
    while (pending_q.size() != 0) @(posedge clk);
    repeat (LATENCY + 8) @(posedge clk);
    cfg_we <= 1'b1;
    cfg_data <= v;
    @(posedge clk);
    cfg_we <= 1'b0;
    thr_shadow = v;
  endtask

  // random item: unit-ish quaternions, near pairs, opposite pairs, raw noise
  function automatic quat_pair_t rand_item();
    quat_pair_t it;
    int kind;
    kind = $urandom_range(0, 9);
    it.sx = 16'($signed($urandom_range(0, 16384)) - 8192);
    it.sy = 16'($signed($urandom_range(0, 16384)) - 8192);
    it.sz = 16'($signed($urandom_range(0, 16384)) - 8192);
    it.sw = 16'($signed($urandom_range(0, 16384)) - 8192);
    it.ex = 16'($signed($urandom_range(0, 16384)) - 8192);
    it.ey = 16'($signed($urandom_range(0, 16384)) - 8192);
    it.ez = 16'($signed($urandom_range(0, 16384)) - 8192);
    it.ew = 16'($signed($urandom_range(0, 16384)) - 8192);
    if (kind < 2) begin
      it.ex = it.sx + 16'($signed($urandom_range(0, 8)) - 4);
      it.ey = it.sy + 16'($signed($urandom_range(0, 8)) - 4);
      it.ez = it.sz + 16'($signed($urandom_range(0, 8)) - 4);
      it.ew = it.sw + 16'($signed($urandom_range(0, 8)) - 4);
    end else if (kind == 2) begin
      it.ex = -it.sx;
      it.ey = -it.sy;
      it.ez = -it.sz;
      it.ew = -it.sw;
    end else if (kind == 3) begin
      it.sx = 16'($urandom); it.sy = 16'($urandom);
      it.sz = 16'($urandom); it.sw = 16'($urandom);
      it.ex = 16'($urandom); it.ey = 16'($urandom);
      it.ez = 16'($urandom); it.ew = 16'($urandom);
    end
    case ($urandom_range(0, 7))
      0: it.blend = 17'($urandom_range(65537, 131071));
      1: it.blend = ($urandom_range(0, 1) != 0) ? 17'd0 : 17'd65536;
      default: it.blend = 17'($urandom_range(0, 65536));
    endcase
    return it;
  endfunction

  // directed rows; expected typed where obvious, otherwise predicted
  typedef struct {
    quat_pair_t item;
    bit         typed;
    slerp_out_t want;
  } table_row_t;

  function automatic table_row_t row(int sx, int sy, int sz, int sw, int ex, int ey, int ez,
                                     int ew, int bl, bit typed = 0, int ox = 0, int oy = 0,
                                     int oz = 0, int ow = 0, bit lin = 0, bit neg = 0);
    table_row_t r;
    r.item = '{16'(sx), 16'(sy), 16'(sz), 16'(sw), 16'(ex), 16'(ey), 16'(ez), 16'(ew),
               17'(bl)};
    r.typed = typed;
    r.want = '{16'(ox), 16'(oy), 16'(oz), 16'(ow), lin, neg};
    return r;
  endfunction

  table_row_t directed[$];

  // output side: random stall and checking
  initial begin
    slerp_out_t exp_r;
    out_ch.ready = 1'b0;
    @(negedge rst);
    forever begin
      int gap;
      gap = pick_gap();
      if (gap > 0) begin
        out_ch.ready <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      out_ch.ready <= 1'b1;
      @(posedge clk);
      while (!out_ch.valid) @(posedge clk);
      results_seen++;
      if (pending_q.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result item at %0t", $realtime);
      end else begin
        exp_r = pending_q.pop_front();
        if (out_ch.out_x !== exp_r.ox || out_ch.out_y !== exp_r.oy ||
            out_ch.out_z !== exp_r.oz || out_ch.out_w !== exp_r.ow ||
            out_ch.linear_used !== exp_r.lin || out_ch.end_negated !== exp_r.neg) begin
          mismatches++;
          if (mismatches <= 10) begin
            $display("mismatch: expected %0d %0d %0d %0d lin %0b neg %0b",
                     exp_r.ox, exp_r.oy, exp_r.oz, exp_r.ow, exp_r.lin, exp_r.neg);
            $display("          got %0d %0d %0d %0d lin %0b neg %0b",
                     out_ch.out_x, out_ch.out_y, out_ch.out_z, out_ch.out_w,
                     out_ch.linear_used, out_ch.end_negated);
          end
        end
        if (exp_r.lin) linear_seen++;
        if (exp_r.neg) negated_seen++;
      end
    end
  end

  // stimulus
  initial begin
    in_ch.valid = 1'b0;
    in_ch.start_x = '0; in_ch.start_y = '0; in_ch.start_z = '0; in_ch.start_w = '0;
    in_ch.end_x = '0; in_ch.end_y = '0; in_ch.end_z = '0; in_ch.end_w = '0;
    in_ch.blend_factor = '0;
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // identical quaternions, linear weights, blend extremes
    directed.push_back(row(0, 0, 0, 16384, 0, 0, 0, 16384, 0, 1, 0, 0, 0, 16384, 1, 0));
    directed.push_back(row(0, 0, 0, 16384, 0, 0, 0, 16384, 65536, 1, 0, 0, 0, 16384, 1, 0));
    // exact zero dot product: not negated, spherical path, all zero output
    directed.push_back(row(0, 0, 0, 0, 0, 0, 0, 0, 32768, 1, 0, 0, 0, 0, 0, 0));
    // blend above one saturates
    directed.push_back(row(0, 0, 0, 16384, 0, 0, 0, 16384, 131071, 1, 0, 0, 0, 16384, 1, 0));
    // negated end, opposite quaternions
    directed.push_back(row(0, 0, 0, 16384, 0, 0, 0, -16384, 0, 1, 0, 0, 0, 16384, 1, 1));
    // orthogonal pair and 45-degree pairs, one with negated end, spherical path
    directed.push_back(row(0, 0, 0, 16384, 16384, 0, 0, 0, 32768));
    directed.push_back(row(16384, 0, 0, 0, 11585, 11585, 0, 0, 16384));
    directed.push_back(row(0, 16384, 0, 0, 0, -11585, 11585, 0, 49152));
    // component extremes, saturation and clamped cosine
    directed.push_back(row(32767, 32767, 32767, 32767, 32767, 32767, 32767, 32767, 32768));
    directed.push_back(row(-32768, -32768, -32768, -32768, -32768, -32768, -32768, -32768,
                           65536));
    directed.push_back(row(-32768, 32767, -32768, 32767, 32767, -32768, 32767, -32768, 1));
    directed.push_back(row(32767, -32768, 0, 0, 0, 0, 32767, -32768, 65535));
    directed.push_back(row(1, 0, 0, 0, 0, 1, 0, 0, 40000));
    directed.push_back(row(0, 0, 16384, 0, 0, 0, 16383, 5, 20000));
    for (int i = 0; i < directed.size(); i++) begin
      quat_pair_t it;
      it = directed[i].item;
      send_item(it);
      if (directed[i].typed) pending_q[pending_q.size() - 1] = directed[i].want;
    end

    // random phases across threshold settings, extremes included
    begin
      logic [THR_W-1:0] thr_set [5];
      thr_set = '{29'd0, 29'd268435456, 29'd26844, 29'h1FFF_FFFF, 29'd1000000};
      for (int ph = 0; ph < 5; ph++) begin
        drain_and_write(ph == 4 ? 29'($urandom_range(1, 50000000)) : thr_set[ph]);
        for (int n = 0; n < 107; n++) send_item(rand_item());
      end
    end
    in_ch.valid <= 1'b0;
    stim_done = 1;
  end

  // end of run
  initial begin
    wait (stim_done);
    while (pending_q.size() != 0) @(posedge clk);
    repeat (LATENCY + 20) @(posedge clk);
    $display("covered %0d results, %0d linear, %0d negated, five threshold settings",
             results_seen, linear_seen, negated_seen);
    if (mismatches == 0 && pending_q.size() == 0)
      $display("status: pass");
    else
      $display("status: fail");
    $finish;
  end

  // watchdog
  initial begin
    #2000000;
    $display("status: fail");
    $finish;
  end
endmodule
